// ----- rtl/skts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skts_pkg
// Shared types and codes for the sorted key table search block.
// ----------------------------------------------------------------------------
package skts_pkg;

  // Width of the index field of a result beat.
  localparam int unsigned IDX_W = 5;

  // A key of nine characters, packed big-endian so that an unsigned compare of
  // the whole vector follows string order.
  typedef struct packed {
    logic [63:0] high;
    logic [7:0]  low;
  } skts_key_t;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_SORT   = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_CLEAR  = 2'd3
  } skts_mode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FOUND   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } skts_status_t;

  // Outcome of the shared key comparator: a below b, a equal to b.
  typedef struct packed {
    logic lt;
    logic eq;
  } skts_cmp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_LOAD,
    S_SORT_WAIT,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_END,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_RESP
  } skts_state_t;

endpackage

// ----- rtl/skts_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skts_ifs
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface skts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] key_high;
  logic [7:0]  key_low;

  modport source (output valid, output mode, output key_high, output key_low, input ready);
  modport sink   (input valid, input mode, input key_high, input key_low, output ready);
endinterface

interface skts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] index;

  modport source (output valid, output status, output index, input ready);
  modport sink   (input valid, input status, input index, output ready);
endinterface

// ----- rtl/sorted_key_table_search_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_search_top
// Key table with append, bubble sort, binary search and clear.
// ----------------------------------------------------------------------------
// Usage: each request beat on in_ch carries a mode and a 72-bit key. Append
// stores the key at the end of the table (status full when there is no room),
// sort orders the table ascending, search looks the key up and clear empties
// the table. Every request gives exactly one result beat on out_ch with a
// status and, for a hit, the index of the matching entry.
// Append, clear and a sort of fewer than two entries go from idle straight to
// the result state. A search checks the window and then compares one probe,
// for at most floor(log2(count))+1 probes, and goes to the result state on a
// hit or when the window is empty. A sort of n entries runs n-1 passes; pass a
// loads the top entry, reads and compares one pair for each position from n-1
// down to a+1, then writes the carried entry at position a. The single read
// port of the key memory and the shared comparator make these steps serial.
// Throughput: one request at a time; in_ch.ready is high only while idle.
// Reset clears the entry count and the state; the key memory is not cleared.
// Back-pressure: the result sits in an output register until taken, and a
// new request is accepted meanwhile; a second finished result then waits
// internally until the register is free.
// ----------------------------------------------------------------------------
module sorted_key_table_search_top #(
  parameter int unsigned DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  skts_in_if.sink           in_ch,
  skts_out_if.source        out_ch
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = CW + 2;
  localparam int unsigned IW = skts_pkg::IDX_W;

  // Control state.
  skts_pkg::skts_state_t  state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Working registers.
  skts_pkg::skts_key_t    key_r, key_nxt;
  skts_pkg::skts_key_t    carry_r, carry_nxt;
  logic [AW-1:0]          a_r, a_nxt;
  logic [AW-1:0]          b_r, b_nxt;
  logic [CW-1:0]          lo_r, lo_nxt;
  logic [CW-1:0]          hip_r, hip_nxt;
  logic [AW-1:0]          mid_r, mid_nxt;
  skts_pkg::skts_status_t res_status_r, res_status_nxt;
  logic [IW-1:0]          res_index_r, res_index_nxt;
  skts_pkg::skts_status_t out_status_r, out_status_nxt;
  logic [IW-1:0]          out_index_r, out_index_nxt;

  // Memory and comparator hookup.
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  skts_pkg::skts_key_t    wr_data;
  logic [AW-1:0]          rd_addr;
  skts_pkg::skts_key_t    rd_data;
  skts_pkg::skts_key_t    cmp_b;
  skts_pkg::skts_cmp_t    cmp;

  // Derived control terms.
  logic                   accept;
  skts_pkg::skts_mode_t   mode_in;
  skts_pkg::skts_key_t    key_in;
  logic [CW-1:0]          cnt_m1;
  logic                   full;
  logic                   few;
  logic                   last_step;
  logic                   sort_over;
  logic                   probe_left;
  logic [CW:0]            mid_sum;
  logic [CW:0]            mid_half;
  logic                   out_free;
  logic [AW+IW-1:0]       mid_ext;

  assign in_ch.ready   = (state_r == skts_pkg::S_IDLE);
  assign accept        = in_ch.valid && in_ch.ready;
  assign mode_in       = skts_pkg::skts_mode_t'(in_ch.mode);
  assign key_in        = {in_ch.key_high, in_ch.key_low};

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.index  = out_index_r;
  assign out_free      = !out_valid_r || out_ch.ready;

  assign cnt_m1     = cnt_r - CW'(1);
  assign full       = (cnt_r >= CW'(DEPTH));
  assign few        = (cnt_r < CW'(2));
  // The pass ends once the pair just above position a has been handled.
  assign last_step  = ((AW + 1)'(b_r) == ((AW + 1)'(a_r) + (AW + 1)'(1)));
  // After pass a the sort is over when a + 2 would reach the count.
  assign sort_over  = ((EW'(a_r) + EW'(3)) > EW'(cnt_r));
  // The search window is [lo, hip), hip being one past the upper bound.
  assign probe_left = (lo_r < hip_r);
  assign mid_sum    = (CW + 1)'(lo_r) + (CW + 1)'(hip_r) - (CW + 1)'(1);
  assign mid_half   = mid_sum >> 1;
  assign mid_ext    = {{IW{1'b0}}, mid_r};

  // The comparator sees the stored entry against the carried key while
  // sorting, and against the request key while searching.
  assign cmp_b = (state_r == skts_pkg::S_SORT_CMP) ? carry_r : key_r;

  skts_key_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  skts_key_cmp u_cmp (
    .a   (rd_data),
    .b   (cmp_b),
    .res (cmp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skts_pkg::S_IDLE: begin
        if (accept) begin
          unique case (mode_in)
            skts_pkg::MODE_APPEND: state_nxt = skts_pkg::S_RESP;
            skts_pkg::MODE_SORT:   state_nxt = few ? skts_pkg::S_RESP : skts_pkg::S_SORT_LOAD;
            skts_pkg::MODE_SEARCH: state_nxt = skts_pkg::S_SRCH_CHK;
            skts_pkg::MODE_CLEAR:  state_nxt = skts_pkg::S_RESP;
          endcase
        end
      end
      skts_pkg::S_SORT_LOAD: state_nxt = skts_pkg::S_SORT_WAIT;
      skts_pkg::S_SORT_WAIT: state_nxt = skts_pkg::S_SORT_RD;
      skts_pkg::S_SORT_RD:   state_nxt = skts_pkg::S_SORT_CMP;
      skts_pkg::S_SORT_CMP:  state_nxt = last_step ? skts_pkg::S_SORT_END : skts_pkg::S_SORT_RD;
      skts_pkg::S_SORT_END:  state_nxt = sort_over ? skts_pkg::S_RESP : skts_pkg::S_SORT_LOAD;
      skts_pkg::S_SRCH_CHK:  state_nxt = probe_left ? skts_pkg::S_SRCH_CMP : skts_pkg::S_RESP;
      skts_pkg::S_SRCH_CMP:  state_nxt = cmp.eq ? skts_pkg::S_RESP : skts_pkg::S_SRCH_CHK;
      skts_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = skts_pkg::S_IDLE;
        end
      end
      default: state_nxt = skts_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    carry_nxt      = carry_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    lo_nxt         = lo_r;
    hip_nxt        = hip_r;
    mid_nxt        = mid_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    wr_en          = 1'b0;
    wr_addr        = b_r;
    wr_data        = carry_r;
    rd_addr        = b_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      skts_pkg::S_IDLE: begin
        if (accept) begin
          key_nxt        = key_in;
          res_status_nxt = skts_pkg::ST_DONE;
          res_index_nxt  = '0;
          unique case (mode_in)
            skts_pkg::MODE_APPEND: begin
              if (full) begin
                res_status_nxt = skts_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cnt_r[AW-1:0];
                wr_data = key_in;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            skts_pkg::MODE_SORT: begin
              a_nxt = '0;
            end
            skts_pkg::MODE_SEARCH: begin
              lo_nxt  = '0;
              hip_nxt = cnt_r;
            end
            skts_pkg::MODE_CLEAR: begin
              cnt_nxt = '0;
            end
          endcase
        end
      end
      skts_pkg::S_SORT_LOAD: begin
        // Fetch the top entry; it starts the carry down through the pass.
        rd_addr = cnt_m1[AW-1:0];
        b_nxt   = cnt_m1[AW-1:0];
      end
      skts_pkg::S_SORT_WAIT: begin
        carry_nxt = rd_data;
      end
      skts_pkg::S_SORT_RD: begin
        rd_addr = b_r - AW'(1);
      end
      skts_pkg::S_SORT_CMP: begin
        // Entry b-1 against the carried entry b: the larger settles at b and
        // the smaller is carried on down.
        wr_en   = 1'b1;
        wr_addr = b_r;
        if (!cmp.lt && !cmp.eq) begin
          wr_data = rd_data;
        end else begin
          wr_data   = carry_r;
          carry_nxt = rd_data;
        end
        b_nxt = b_r - AW'(1);
      end
      skts_pkg::S_SORT_END: begin
        wr_en   = 1'b1;
        wr_addr = a_r;
        wr_data = carry_r;
        a_nxt   = a_r + AW'(1);
      end
      skts_pkg::S_SRCH_CHK: begin
        if (probe_left) begin
          rd_addr = mid_half[AW-1:0];
          mid_nxt = mid_half[AW-1:0];
        end else begin
          res_status_nxt = skts_pkg::ST_MISSING;
          res_index_nxt  = '0;
        end
      end
      skts_pkg::S_SRCH_CMP: begin
        if (cmp.eq) begin
          res_status_nxt = skts_pkg::ST_FOUND;
          res_index_nxt  = mid_ext[IW-1:0];
        end else if (cmp.lt) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else begin
          hip_nxt = CW'(mid_r);
        end
      end
      skts_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_index_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skts_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    carry_r      <= carry_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    lo_r         <= lo_nxt;
    hip_r        <= hip_nxt;
    mid_r        <= mid_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  // The entry count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // Writes made while sorting stay inside the filled part of the table.
  a_sort_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (state_r != skts_pkg::S_IDLE)) |-> (CW'(wr_addr) < cnt_r))
    else $error("sort write outside filled entries");

  // A search probe always lands on a filled entry.
  a_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skts_pkg::S_SRCH_CMP) |-> (CW'(mid_r) < cnt_r))
    else $error("search probe outside filled entries");

  // Every accepted request takes the block out of idle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("request accepted without leaving idle");

  // A finished result reaches the output register once it is free.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == skts_pkg::S_RESP) && out_free) |=> out_valid_r)
    else $error("finished result not presented");

endmodule

// ----- rtl/skts_key_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skts_key_store
// Key memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module skts_key_store #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  skts_pkg::skts_key_t          wr_data,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output skts_pkg::skts_key_t          rd_data
);

  skts_pkg::skts_key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/skts_key_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skts_key_cmp
// Shared 72-bit unsigned key comparator used by both sort and search.
// ----------------------------------------------------------------------------
module skts_key_cmp (
  input  skts_pkg::skts_key_t a,
  input  skts_pkg::skts_key_t b,
  output skts_pkg::skts_cmp_t res
);

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule
